[sv/assert_macros.svh]
// Assertion macros shared by the level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/llm_pkg.sv]
// Package with widths, shared types and log2 tables of the level meter.
`timescale 1ns / 1ps

package llm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MAG_W = 17;
   localparam int LEN_W = 11;
   localparam int CNT_W = 10;
   localparam int SUM_W = 26;
   localparam int DIGIT_W = 4;
   localparam int ACC_DIGITS = 7;
   localparam int ACC_W = DIGIT_W * ACC_DIGITS;
   localparam int DIGIT_CNT_W = 3;
   localparam int DEN_W = 25;
   localparam int NUM9_W = 29;
   localparam int QUOT_W = 20;
   localparam int STEP_W = 5;
   localparam int LEVEL_W = 16;
   localparam int LG2_W = 18;
   localparam int PROD_W = 25;
   localparam int SCALE_W = 37;

   localparam logic [LEN_W-1:0] MAX_BLOCK = 11'd1024;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd160;
   localparam logic [QUOT_W-1:0] SAT_QUOT = 20'd589824;
   localparam logic [18:0] LOG10_2_Q20 = 19'd315653;
   localparam logic [SCALE_W-1:0] ROUND_Q20 = 37'd524288;
   localparam logic [LEVEL_W-1:0] SAT_LEVEL = 16'hFFFF;

   typedef struct packed {
      logic done;
      logic sat;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

   typedef struct packed {
      logic done;
      logic [LEVEL_W-1:0] level;
   } log_res_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ACC  = 6'b000010,
      ST_LOAD = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_LOG  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   function automatic logic [15:0] log2_base(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'd0: val = 16'd0;
         4'd1: val = 16'd5732;
         4'd2: val = 16'd11136;
         4'd3: val = 16'd16248;
         4'd4: val = 16'd21098;
         4'd5: val = 16'd25711;
         4'd6: val = 16'd30109;
         4'd7: val = 16'd34312;
         4'd8: val = 16'd38336;
         4'd9: val = 16'd42196;
         4'd10: val = 16'd45904;
         4'd11: val = 16'd49472;
         4'd12: val = 16'd52911;
         4'd13: val = 16'd56229;
         4'd14: val = 16'd59434;
         4'd15: val = 16'd62534;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   function automatic logic [12:0] log2_step(input logic [3:0] idx);
      logic [12:0] val;
      case (idx)
         4'd0: val = 13'd5732;
         4'd1: val = 13'd5404;
         4'd2: val = 13'd5112;
         4'd3: val = 13'd4850;
         4'd4: val = 13'd4613;
         4'd5: val = 13'd4398;
         4'd6: val = 13'd4203;
         4'd7: val = 13'd4024;
         4'd8: val = 13'd3860;
         4'd9: val = 13'd3708;
         4'd10: val = 13'd3568;
         4'd11: val = 13'd3439;
         4'd12: val = 13'd3318;
         4'd13: val = 13'd3205;
         4'd14: val = 13'd3100;
         4'd15: val = 13'd3002;
         default: val = 13'd0;
      endcase
      return val;
   endfunction

endpackage

[sv/llm_div.sv]
// Bit-serial restoring divider that scales the block sum to the Q16 mean.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module llm_div
   import llm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [SUM_W-1:0] sum,
   input  logic [LEN_W-1:0] len,
   output div_res_type res
);

   logic busy_ff, busy_in;
   logic prep_ff, prep_in;
   logic done_ff, done_in;
   logic sat_ff, sat_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM9_W-1:0] num9_ff, num9_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic ge;
   logic [DEN_W-1:0] hi;
   logic [LEN_W+14:0] den_full;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign diff = trial - {1'b0, den_ff};
   assign ge = trial >= {1'b0, den_ff};
   assign hi = num9_ff[NUM9_W-1:4];
   assign den_full = {len, 15'd0} - {15'd0, len};

   always_comb begin
      busy_in = busy_ff;
      prep_in = prep_ff;
      done_in = 1'b0;
      sat_in = sat_ff;
      step_in = step_ff;
      den_in = den_ff;
      num9_in = num9_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         prep_in = 1'b1;
         den_in = den_full[DEN_W-1:0];
         num9_in = {sum, 3'd0} + {3'd0, sum};
      end else if (busy_ff && prep_ff) begin
         prep_in = 1'b0;
         sat_in = hi >= den_ff;
         rem_in = hi;
         quo_in = {num9_ff[3:0], 16'd0};
         step_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         prep_ff <= prep_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
      den_ff <= den_in;
      num9_ff <= num9_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign res.done = done_ff;
   assign res.sat = sat_ff;
   assign res.quot = quo_ff;

   `ASSERT_NEVER(a_div_start_busy, clock, reset, start && busy_ff,
      "divider started while a division is in progress")
   `ASSERT_ALWAYS(a_div_done_pulse, clock, reset, done_ff |=> !done_ff,
      "divider done lasted more than one cycle")

endmodule

[sv/llm_log.sv]
// Pipelined log10 mapping of the Q16 mean by table and interpolation.
`timescale 1ns / 1ps

module llm_log
   import llm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  div_res_type div_res,
   output log_res_type res
);

   logic [20:0] v;
   logic [1:0] e_in;
   logic [15:0] f_in;

   logic s1_ff, s2_ff, s3_ff, done_ff;
   logic sat1_ff, sat2_ff, sat3_ff;
   logic [1:0] e1_ff;
   logic [15:0] f1_ff;
   logic [PROD_W-1:0] prod2_ff;
   logic [LG2_W-1:0] base2_ff;
   logic [LG2_W-1:0] lg2_3_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [SCALE_W-1:0] scaled;

   assign v = {1'b0, div_res.quot} + 21'd65536;

   always_comb begin
      if (v[19]) begin
         e_in = 2'd3;
         f_in = v[18:3];
      end else if (v[18]) begin
         e_in = 2'd2;
         f_in = v[17:2];
      end else if (v[17]) begin
         e_in = 2'd1;
         f_in = v[16:1];
      end else begin
         e_in = 2'd0;
         f_in = v[15:0];
      end
   end

   assign scaled = {{(SCALE_W-LG2_W){1'b0}}, lg2_3_ff} * {{(SCALE_W-19){1'b0}}, LOG10_2_Q20}
      + ROUND_Q20;

   always_comb begin
      if (sat3_ff || scaled[SCALE_W-1] || scaled[36]) begin
         level_in = SAT_LEVEL;
      end else begin
         level_in = scaled[35:20];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_ff <= div_res.done;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         done_ff <= s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sat1_ff <= div_res.sat || (div_res.quot >= SAT_QUOT);
      e1_ff <= e_in;
      f1_ff <= f_in;
      sat2_ff <= sat1_ff;
      prod2_ff <= {12'd0, log2_step(f1_ff[15:12])} * {13'd0, f1_ff[11:0]};
      base2_ff <= {e1_ff, 16'd0} + {2'd0, log2_base(f1_ff[15:12])};
      sat3_ff <= sat2_ff;
      lg2_3_ff <= base2_ff + {5'd0, prod2_ff[PROD_W-1:12]};
      if (s3_ff) begin
         level_ff <= level_in;
      end
   end

   assign res.done = done_ff;
   assign res.level = level_ff;

endmodule

[sv/log_audio_level_meter.sv]
// Top level of the log-scale audio level meter with peak hold.
//
//   channel  direction  transaction
//   req_     in         one signed 16-bit sample
//   rsp_     out        block level and running peak, both unsigned Q0.16
//   csr_     in         block length write, taken in any cycle
//
// A sample is accepted in ST_IDLE, and then ST_ACC adds its magnitude into the block
// sum four bits per cycle. After the last sample of a block, ST_LOAD starts the
// bit-serial divider (a setup step, then 20 quotient bits at one per cycle), the log
// pipeline maps the quotient, and ST_OUT loads the result.
// A result waits in the output register while the next block accumulates; the
// finished level of the following block waits until that register is free.
// Synchronous reset clears the block sum, sample count and peak and sets the block
// length to 160.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module log_audio_level_meter
   import llm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [LEVEL_W-1:0] rsp_level,
   output logic [LEVEL_W-1:0] rsp_peak_level,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [LEN_W-1:0] csr_block_length
);

   state_type state_ff, state_in;
   logic [LEN_W-1:0] block_length_ff;
   logic [LEN_W-1:0] eff_len;
   logic [ACC_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0] mag_ff, mag_in;
   logic carry_ff, carry_in;
   logic [DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic [CNT_W-1:0] sample_count_ff, sample_count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [MAG_W-1:0] sext;
   logic [MAG_W-1:0] mag;
   logic [DIGIT_W:0] digit_sum;
   logic block_end;
   logic div_start;
   logic load_out;
   div_res_type div_res;
   log_res_type log_res;

   localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(ACC_DIGITS - 1);

   always_comb begin
      if (block_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (block_length_ff > MAX_BLOCK) begin
         eff_len = MAX_BLOCK;
      end else begin
         eff_len = block_length_ff;
      end
   end

   assign sext = {req_sample[SAMPLE_W-1], req_sample};
   assign mag = sext[MAG_W-1] ? (~sext + MAG_W'(1)) : sext;
   assign digit_sum = {1'b0, sum_ff[DIGIT_W-1:0]} + {1'b0, mag_ff[DIGIT_W-1:0]}
      + {{DIGIT_W{1'b0}}, carry_ff};
   assign block_end = ({1'b0, sample_count_ff} + LEN_W'(1)) >= eff_len;
   assign req_ready = state_ff == ST_IDLE;
   assign div_start = state_ff == ST_LOAD;
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      sum_in = sum_ff;
      mag_in = mag_ff;
      carry_in = carry_ff;
      digit_in = digit_ff;
      sample_count_in = sample_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in = {{(ACC_W-MAG_W){1'b0}}, mag};
               carry_in = 1'b0;
               digit_in = '0;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in = {digit_sum[DIGIT_W-1:0], sum_ff[ACC_W-1:DIGIT_W]};
            mag_in = {{DIGIT_W{1'b0}}, mag_ff[ACC_W-1:DIGIT_W]};
            carry_in = digit_sum[DIGIT_W];
            digit_in = digit_ff + DIGIT_CNT_W'(1);
            if (digit_ff == LAST_DIGIT) begin
               if (block_end) begin
                  state_in = ST_LOAD;
               end else begin
                  sample_count_in = sample_count_ff + CNT_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOAD: begin
            sum_in = '0;
            sample_count_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            if (log_res.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      peak_in = peak_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = log_res.level;
         if (log_res.level > peak_ff) begin
            peak_in = log_res.level;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         block_length_ff <= LEN_RESET;
         sum_ff <= '0;
         sample_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         peak_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            block_length_ff <= csr_block_length;
         end
         sum_ff <= sum_in;
         sample_count_ff <= sample_count_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      carry_ff <= carry_in;
      digit_ff <= digit_in;
      rsp_level_ff <= rsp_level_in;
   end

   llm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sum_ff[SUM_W-1:0]),
      .len   (eff_len),
      .res   (div_res)
   );

   llm_log u_log (
      .clock   (clock),
      .reset   (reset),
      .div_res (div_res),
      .res     (log_res)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_peak_level = peak_ff;

   `ASSERT_ALWAYS(a_rsp_from_out, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT),
      "response appeared without a finished block")
   `ASSERT_NEVER(a_peak_below_level, clock, reset,
      rsp_valid_ff && (peak_ff < rsp_level_ff),
      "peak level is below the level it was updated with")
   `ASSERT_NEVER(a_block_cleared, clock, reset,
      (state_ff == ST_DIV) && ((sum_ff != '0) || (sample_count_ff != '0)),
      "block sum or sample count was not cleared after the last sample")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the log-scale audio level meter with peak hold.
`timescale 1ns / 1ps

module tb_top;
   import llm_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
   } meter_result_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   localparam int unsigned LOG2_FRAC_Q16 [17] = '{
      0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
      42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
   };
   localparam int SETTLE_CYCLES = 64;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD = 400;
   localparam int ITEM_GOAL = 1800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [LEVEL_W-1:0] rsp_level;
   logic [LEVEL_W-1:0] rsp_peak_level;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LEN_W-1:0] csr_block_length = '0;

   log_audio_level_meter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_level(rsp_level),
      .rsp_peak_level(rsp_peak_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_block_length(csr_block_length)
   );

   logic [SAMPLE_W-1:0] sample_queue[$];
   meter_result_type expected_levels[$];
   int unsigned samples_pushed = 0;
   int unsigned samples_accepted = 0;
   int unsigned levels_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned error_count = 0;
   logic req_taken = 1'b0;

   logic [LEN_W-1:0] model_length = LEN_RESET;
   longint unsigned model_sum = 0;
   int unsigned model_count = 0;
   logic [LEVEL_W-1:0] model_peak = '0;

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned window_left = 0;
   rx_mode_type rx_mode = RX_STEADY;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d block levels still pending.", expected_levels.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned effective_length(input logic [LEN_W-1:0] len);
      int unsigned n;
      n = len;
      if (n == 0) n = 1;
      if (n > MAX_BLOCK) n = MAX_BLOCK;
      return n;
   endfunction

   function automatic logic [LEVEL_W-1:0] log_level_q16(input longint unsigned sum,
                                                        input int unsigned len);
      longint unsigned quot, v, f, lg2, lvl;
      int unsigned e, i, r;
      quot = (sum * 64'd9 * 64'd65536) / (longint'(len) * 64'd32767);
      v = 64'd65536 + quot;
      if (v >= 64'd655360) return 16'hFFFF;
      e = 0;
      while (e < 3 && v >= (64'd65536 << (e + 1))) e++;
      f = ((v - (64'd65536 << e)) >> e) & 64'hFFFF;
      i = f >> 12;
      r = f & 64'd4095;
      lg2 = longint'(e) * 64'd65536 + LOG2_FRAC_Q16[i] +
            ((longint'(LOG2_FRAC_Q16[i + 1] - LOG2_FRAC_Q16[i]) * r) >> 12);
      lvl = (lg2 * 64'd315653 + 64'd524288) >> 20;
      if (lvl > 64'd65535) lvl = 64'd65535;
      return lvl[LEVEL_W-1:0];
   endfunction

   function automatic bit meter_take_sample(input logic [SAMPLE_W-1:0] s,
                                            output meter_result_type res);
      int unsigned mag, len;
      logic [LEVEL_W-1:0] lvl;
      mag = s[SAMPLE_W-1] ? (32'h10000 - s) : s;
      len = effective_length(model_length);
      model_sum += mag;
      res = '0;
      if (model_count + 1 < len) begin
         model_count++;
         return 1'b0;
      end
      lvl = log_level_q16(model_sum, len);
      if (lvl > model_peak) model_peak = lvl;
      model_sum = 0;
      model_count = 0;
      res.level = lvl;
      res.peak = model_peak;
      return 1'b1;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_sample <= sample_queue.pop_front();
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 32);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (window_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
            window_left <= $urandom_range(16, 96);
         end else begin
            window_left <= window_left - 1;
         end
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      meter_result_type fresh;
      meter_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: result with no block pending, level %0d peak %0d",
                        $time, rsp_level, rsp_peak_level);
               error_count++;
            end else begin
               want = expected_levels.pop_front();
               levels_checked++;
               if (rsp_level !== want.level) begin
                  $display("%0t: level mismatch, expected %0d, got %0d",
                           $time, want.level, rsp_level);
                  error_count++;
               end
               if (rsp_peak_level !== want.peak) begin
                  $display("%0t: peak mismatch, expected %0d, got %0d",
                           $time, want.peak, rsp_peak_level);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            model_length = csr_block_length;
            csr_writes <= csr_writes + 1;
         end
         if (req_valid && req_ready) begin
            samples_accepted <= samples_accepted + 1;
            if (meter_take_sample(req_sample, fresh)) expected_levels.push_back(fresh);
         end
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      sample_queue.push_back(s);
      samples_pushed++;
   endtask

   task automatic push_audio(input int unsigned n, input int unsigned amp);
      int unsigned mag;
      logic [SAMPLE_W-1:0] s;
      for (int unsigned k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               mag = $urandom_range(0, 1 << amp);
               s = mag[SAMPLE_W-1:0];
               if ($urandom_range(0, 1)) s = -s;
            end
            6, 7: s = SAMPLE_W'($urandom);
            default: begin
               case ($urandom_range(0, 3))
                  0: s = 16'h8000;
                  1: s = 16'h7FFF;
                  2: s = 16'h0000;
                  default: s = 16'hFFFF;
               endcase
            end
         endcase
         push_sample(s);
      end
   endtask

   task automatic settle_meter(input int cycles);
      while (samples_accepted != samples_pushed || expected_levels.size() != 0)
         @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic set_block_length(input logic [LEN_W-1:0] len);
      int unsigned seen;
      seen = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_block_length <= len;
      @(negedge clock);
      while (csr_writes == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned pick, eff, n, span;
      logic [LEN_W-1:0] len;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_audio(160, 12);
      settle_meter(SETTLE_CYCLES);

      set_block_length(11'd1);
      push_sample(16'h0000);
      push_sample(16'h0001);
      push_sample(16'hFFFF);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h5555);
      push_sample(16'hAAAA);
      push_sample(16'h0100);
      settle_meter(SETTLE_CYCLES);
      set_block_length(11'd4);
      repeat (3) push_sample(16'h8000);
      settle_meter(SETTLE_CYCLES);
      set_block_length(11'd1);
      push_sample(16'h3039);
      settle_meter(SETTLE_CYCLES);
      set_block_length(11'd0);
      push_sample(16'h0040);
      push_sample(16'hC000);
      push_sample(16'h7FFF);
      settle_meter(SETTLE_CYCLES);

      set_block_length(11'd1);
      hold_request = 1'b1;
      push_audio(80, 14);
      settle_meter(SETTLE_CYCLES);

      set_block_length(11'd1025);
      push_audio(100, 9);
      settle_meter(SETTLE_CYCLES);
      set_block_length(11'd2047);
      push_audio(1024, 10);
      settle_meter(SETTLE_CYCLES);
      set_block_length(11'd1024);
      push_audio(40, 15);
      settle_meter(SETTLE_CYCLES);

      while (samples_pushed < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) len = LEN_W'($urandom_range(1, 16));
         else if (pick < 80) len = LEN_W'($urandom_range(17, 200));
         else if (pick < 90) len = LEN_W'($urandom_range(0, 3));
         else len = LEN_W'($urandom_range(0, 2047));
         eff = effective_length(len);
         if (eff <= 200) begin
            span = 120 / eff;
            if (span == 0) span = 1;
            n = eff * $urandom_range(1, span);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(0, eff - 1);
         end else begin
            n = $urandom_range(1, 300);
         end
         set_block_length(len);
         push_audio(n, $urandom_range(0, 15));
         settle_meter(SETTLE_CYCLES);
      end

      settle_meter(DRAIN_CYCLES);
      if (expected_levels.size() != 0) begin
         $display("%0d block levels never arrived.", expected_levels.size());
         error_count += expected_levels.size();
      end
      $display("Sent %0d samples across %0d block length writes, from 0 up to 2047.",
               samples_accepted, csr_writes);
      $display("Checked %0d block levels and peaks, %0d mismatches.",
               levels_checked, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
